// ===== rtl/z2hb_pkg.sv =====
package z2hb_pkg;

    localparam int TIME_LEN_DEF  = 40;
    localparam int SPACE_LEN_DEF = 10;

    // sigmoid table, Q0.16 entries over x in [-8, 8)
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

    // read sequence codes: row of c, row of c+u, then per other direction v
    // (j = 0..2) the rows c-v, c-v+u and c+v
    localparam logic [3:0] RD_C    = 4'd0;
    localparam logic [3:0] RD_CU   = 4'd1;
    localparam logic [3:0] RD_MV0  = 4'd2;
    localparam logic [3:0] RD_MVU0 = 4'd3;
    localparam logic [3:0] RD_PV0  = 4'd4;
    localparam logic [3:0] RD_MV1  = 4'd5;
    localparam logic [3:0] RD_MVU1 = 4'd6;
    localparam logic [3:0] RD_PV1  = 4'd7;
    localparam logic [3:0] RD_MV2  = 4'd8;
    localparam logic [3:0] RD_MVU2 = 4'd9;
    localparam logic [3:0] RD_PV2  = 4'd10;
    localparam logic [3:0] RD_LAST = RD_PV2;

    typedef struct packed {
        logic       load;
        logic       reduce;
        logic       clr;
        logic       rd_en;
        logic [3:0] rd_sel;
        logic       sum;
        logic       mul;
        logic       decide;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic clr_last;
        logic func;
    } sts_t;

    typedef struct packed {
        logic [1:0] j;
        logic       inc_u;
        logic       dec_v;
        logic       inc_v;
    } rd_dec_t;

    function automatic rd_dec_t rd_decode(input logic [3:0] sel);
        rd_dec_t d;
        d = '0;
        case (sel)
            RD_C:    ;
            RD_CU:   d.inc_u = 1'b1;
            RD_MV0:  begin d.j = 2'd0; d.dec_v = 1'b1; end
            RD_MVU0: begin d.j = 2'd0; d.dec_v = 1'b1; d.inc_u = 1'b1; end
            RD_PV0:  begin d.j = 2'd0; d.inc_v = 1'b1; end
            RD_MV1:  begin d.j = 2'd1; d.dec_v = 1'b1; end
            RD_MVU1: begin d.j = 2'd1; d.dec_v = 1'b1; d.inc_u = 1'b1; end
            RD_PV1:  begin d.j = 2'd1; d.inc_v = 1'b1; end
            RD_MV2:  begin d.j = 2'd2; d.dec_v = 1'b1; end
            RD_MVU2: begin d.j = 2'd2; d.dec_v = 1'b1; d.inc_u = 1'b1; end
            RD_PV2:  begin d.j = 2'd2; d.inc_v = 1'b1; end
            default: ;
        endcase
        return d;
    endfunction

    // j-th direction other than u, ascending
    function automatic logic [1:0] dir_of(input logic [1:0] j, input logic [1:0] u);
        return (j >= u) ? j + 2'd1 : j;
    endfunction

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] sig_at(input int i);
        longint      m;
        logic [63:0] one, ax, s, s2, s3, s4, e, den, num, p;
        one = 64'd1 << 30;
        m   = -longint'(32768) + longint'(((2 * i + 1) * 32768) / SIG_ENTRIES);
        ax  = (m < 0) ? 64'(-m) : 64'(m);
        s   = ax << 10;
        s2  = (s * s) >> 30;
        s3  = (s2 * s) >> 30;
        s4  = (s3 * s) >> 30;
        e   = one - s + s2 / 2 - s3 / 6 + s4 / 24;
        for (int k = 0; k < 8; k++) begin
            e = (e * e) >> 30;
        end
        den = one + e;
        num = (m < 0) ? e : one;
        p   = udiv64((num << 16) + (den >> 1), den);
        if (p > 64'd65535) begin
            p = 64'd65535;
        end
        return p[15:0];
    endfunction

    typedef logic [15:0] sig_tab_t [SIG_ENTRIES];

    function automatic sig_tab_t sig_build();
        sig_tab_t t;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            t[i] = sig_at(i);
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

// ===== rtl/z2hb_ram.sv =====
module z2hb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/z2hb_ctrl.sv =====
module z2hb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  z2hb_pkg::sts_t  sts,
    output logic            busy,
    output z2hb_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_WAIT,
        ST_SUM,
        ST_MUL,
        ST_DECIDE
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rd_cnt_reg, rd_cnt_next;

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd         = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (sts.in_range)
                begin
                    rd_cnt_next = z2hb_pkg::RD_C;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rd_cnt_reg;
                // a write request only needs the row of its own site
                if (rd_cnt_reg == (sts.func ? z2hb_pkg::RD_C : z2hb_pkg::RD_LAST))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 4'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = sts.func ? ST_DECIDE : ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rd_cnt_reg <= z2hb_pkg::RD_LAST))
        else $error("read counter past sequence end");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(state_reg) == ST_DECIDE || $past(state_reg) == ST_CLEAR))
        else $error("busy dropped outside decide or clear");

endmodule

// ===== rtl/z2hb_dp.sv =====
module z2hb_dp #(
    parameter int TIME_LEN  = z2hb_pkg::TIME_LEN_DEF,
    parameter int SPACE_LEN = z2hb_pkg::SPACE_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  z2hb_pkg::cmd_t      cmd,
    output z2hb_pkg::sts_t      sts,
    input  logic                func,
    input  logic [5:0]          time_coord,
    input  logic [3:0]          x_coord,
    input  logic [3:0]          y_coord,
    input  logic [3:0]          z_coord,
    input  logic [1:0]          direction,
    input  logic                write_sign,
    input  logic [15:0]         random_fraction,
    input  logic [15:0]         coupling_time,
    input  logic [15:0]         coupling_space,
    output logic                done,
    output logic                new_sign,
    output logic signed [3:0]   time_staple_sum,
    output logic signed [3:0]   space_staple_sum
);

    localparam int DEPTH = TIME_LEN * SPACE_LEN * SPACE_LEN * SPACE_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int TCW   = ($clog2(TIME_LEN) > 6) ? $clog2(TIME_LEN) : 6;
    localparam int SCW   = ($clog2(SPACE_LEN) > 4) ? $clog2(SPACE_LEN) : 4;

    // request registers
    logic               func_reg, wsign_reg;
    logic [1:0]         u_reg;
    logic [TCW-1:0]     t_reg;
    logic [SCW-1:0]     x_reg, y_reg, z_reg;
    logic [15:0]        rand_reg, ct_reg, cs_reg;

    // fetched link bits
    logic [3:0]         rowc_reg, rowcu_reg;
    logic [2:0]         b1_reg, b2_reg;
    logic               rdv_q_reg;
    logic [3:0]         sel_q_reg;

    logic signed [3:0]  tsum_reg, ssum_reg;
    logic signed [21:0] xs_reg;
    logic [AW-1:0]      clr_cnt_reg;

    logic               done_reg, sign_reg;
    logic signed [3:0]  tout_reg, sout_reg;

    function automatic logic [TCW-1:0] step_t(input logic [TCW-1:0] c,
                                               input logic inc, input logic dec);
        logic [TCW-1:0] r;
        r = c;
        if (inc)
        begin
            r = (c == TCW'(TIME_LEN - 1)) ? '0 : c + 1'b1;
        end
        else if (dec)
        begin
            r = (c == '0) ? TCW'(TIME_LEN - 1) : c - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [SCW-1:0] step_s(input logic [SCW-1:0] c,
                                               input logic inc, input logic dec);
        logic [SCW-1:0] r;
        r = c;
        if (inc)
        begin
            r = (c == SCW'(SPACE_LEN - 1)) ? '0 : c + 1'b1;
        end
        else if (dec)
        begin
            r = (c == '0) ? SCW'(SPACE_LEN - 1) : c - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [TCW-1:0] t,
                                              input logic [SCW-1:0] x,
                                              input logic [SCW-1:0] y,
                                              input logic [SCW-1:0] z);
        return ((AW'(t) * AW'(SPACE_LEN) + AW'(x)) * AW'(SPACE_LEN) + AW'(y))
               * AW'(SPACE_LEN) + AW'(z);
    endfunction

    // address generation for the current read
    z2hb_pkg::rd_dec_t rd_d, cap_d;
    logic [1:0]        rd_v, cap_v;
    logic [3:0]        inc_d, dec_d;
    logic [AW-1:0]     raddr, waddr, addr_c;
    logic [3:0]        rdata, wdata;
    logic              we;

    always_comb
    begin
        rd_d = z2hb_pkg::rd_decode(cmd.rd_sel);
        rd_v = z2hb_pkg::dir_of(rd_d.j, u_reg);
        for (int d = 0; d < 4; d++)
        begin
            inc_d[d] = (rd_d.inc_u && u_reg == 2'(d)) || (rd_d.inc_v && rd_v == 2'(d));
            dec_d[d] = rd_d.dec_v && rd_v == 2'(d);
        end
        raddr  = addr_of(step_t(t_reg, inc_d[0], dec_d[0]),
                         step_s(x_reg, inc_d[1], dec_d[1]),
                         step_s(y_reg, inc_d[2], dec_d[2]),
                         step_s(z_reg, inc_d[3], dec_d[3]));
        addr_c = addr_of(t_reg, x_reg, y_reg, z_reg);
    end

    // decision
    logic [15:0]          xc, xo;
    logic [15:0]          prob;
    logic                 sign_new;

    always_comb
    begin
        if (xs_reg > 22'sd32767)
        begin
            xc = 16'h7FFF;
        end
        else if (xs_reg < -22'sd32768)
        begin
            xc = 16'h8000;
        end
        else
        begin
            xc = xs_reg[15:0];
        end
        xo       = {~xc[15], xc[14:0]};
        prob     = z2hb_pkg::SIG_TABLE[xo[15 -: z2hb_pkg::SIG_IDX_W]];
        sign_new = func_reg ? wsign_reg : !(rand_reg < prob);
        wdata    = rowc_reg;
        if (cmd.clr)
        begin
            wdata = '0;
        end
        else
        begin
            wdata[u_reg] = sign_new;
        end
        we    = cmd.clr || cmd.decide;
        waddr = cmd.clr ? clr_cnt_reg : addr_c;
    end

    z2hb_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // staple sums
    logic signed [3:0] tsum_next, ssum_next;
    logic [1:0]        sv;

    always_comb
    begin
        tsum_next = '0;
        ssum_next = '0;
        sv        = '0;
        for (int j = 0; j < 3; j++)
        begin
            sv = z2hb_pkg::dir_of(2'(j), u_reg);
            if (u_reg == 2'd0 || sv == 2'd0)
            begin
                tsum_next = tsum_next + ((b1_reg[j] & b2_reg[j]) ? -4'sd2 :
                            ((b1_reg[j] ^ b2_reg[j]) ? 4'sd0 : 4'sd2));
            end
            else
            begin
                ssum_next = ssum_next + ((b1_reg[j] & b2_reg[j]) ? -4'sd2 :
                            ((b1_reg[j] ^ b2_reg[j]) ? 4'sd0 : 4'sd2));
            end
        end
    end

    logic signed [21:0] pt, ps;
    always_comb
    begin
        pt = 22'(signed'({1'b0, ct_reg})) * 22'(tsum_reg);
        ps = 22'(signed'({1'b0, cs_reg})) * 22'(ssum_reg);
    end

    assign cap_d = z2hb_pkg::rd_decode(sel_q_reg);
    assign cap_v = z2hb_pkg::dir_of(cap_d.j, u_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            wsign_reg <= write_sign;
            u_reg     <= direction;
            t_reg     <= TCW'(time_coord);
            x_reg     <= SCW'(x_coord);
            y_reg     <= SCW'(y_coord);
            z_reg     <= SCW'(z_coord);
            rand_reg  <= random_fraction;
            ct_reg    <= coupling_time;
            cs_reg    <= coupling_space;
        end
        if (cmd.reduce)
        begin
            if (32'(t_reg) >= TIME_LEN)  t_reg <= t_reg - TCW'(TIME_LEN);
            if (32'(x_reg) >= SPACE_LEN) x_reg <= x_reg - SCW'(SPACE_LEN);
            if (32'(y_reg) >= SPACE_LEN) y_reg <= y_reg - SCW'(SPACE_LEN);
            if (32'(z_reg) >= SPACE_LEN) z_reg <= z_reg - SCW'(SPACE_LEN);
        end
        sel_q_reg <= cmd.rd_sel;
        if (rdv_q_reg)
        begin
            case (sel_q_reg)
                z2hb_pkg::RD_C:  rowc_reg  <= rdata;
                z2hb_pkg::RD_CU: rowcu_reg <= rdata;
                z2hb_pkg::RD_MV0, z2hb_pkg::RD_MV1, z2hb_pkg::RD_MV2:
                    b1_reg[cap_d.j] <= rdata[u_reg] ^ rdata[cap_v];
                z2hb_pkg::RD_MVU0, z2hb_pkg::RD_MVU1, z2hb_pkg::RD_MVU2:
                    b1_reg[cap_d.j] <= b1_reg[cap_d.j] ^ rdata[cap_v];
                z2hb_pkg::RD_PV0, z2hb_pkg::RD_PV1, z2hb_pkg::RD_PV2:
                    b2_reg[cap_d.j] <= rdata[u_reg] ^ rowc_reg[cap_v] ^ rowcu_reg[cap_v];
                default: ;
            endcase
        end
        if (cmd.sum)
        begin
            tsum_reg <= tsum_next;
            ssum_reg <= ssum_next;
        end
        if (cmd.mul)
        begin
            xs_reg <= pt + ps;
        end
        if (cmd.decide)
        begin
            sign_reg <= sign_new;
            tout_reg <= func_reg ? 4'sd0 : tsum_reg;
            sout_reg <= func_reg ? 4'sd0 : ssum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_q_reg   <= 1'b0;
            done_reg    <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            rdv_q_reg <= cmd.rd_en;
            done_reg  <= cmd.decide;
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign sts.in_range = (32'(t_reg) < TIME_LEN) && (32'(x_reg) < SPACE_LEN)
                          && (32'(y_reg) < SPACE_LEN) && (32'(z_reg) < SPACE_LEN);
    assign sts.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.func     = func_reg;

    assign done             = done_reg;
    assign new_sign         = sign_reg;
    assign time_staple_sum  = tout_reg;
    assign space_staple_sum = sout_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/z2_gauge_heatbath_link_update.sv =====
// channel   ports                                           handshake
// request   func, time_coord, x_coord, y_coord, z_coord,    start & !busy
//           direction, write_sign, random_fraction,
//           coupling_time, coupling_space
// result    new_sign, time_staple_sum, space_staple_sum     done (one cycle)
//
// Update request: accept, then reduce steps that wrap out-of-range coordinates by
// subtracting the lattice length, then eleven row reads on the single read port
// of the link store, a wait for the last row, then sum, multiply and decide.
// Write request: one row read, then read-modify-write.
// After reset the store is cleared one site row a cycle, TIME_LEN*SPACE_LEN^3
// rows (40000 by default), with busy high.
// Results cannot be held off; done pulses for one cycle per request.
module z2_gauge_heatbath_link_update #(
    parameter int TIME_LEN  = z2hb_pkg::TIME_LEN_DEF,
    parameter int SPACE_LEN = z2hb_pkg::SPACE_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic [5:0]        time_coord,
    input  logic [3:0]        x_coord,
    input  logic [3:0]        y_coord,
    input  logic [3:0]        z_coord,
    input  logic [1:0]        direction,
    input  logic              write_sign,
    input  logic [15:0]       random_fraction,
    input  logic [15:0]       coupling_time,
    input  logic [15:0]       coupling_space,
    output logic              done,
    output logic              new_sign,
    output logic signed [3:0] time_staple_sum,
    output logic signed [3:0] space_staple_sum
);

    z2hb_pkg::cmd_t cmd;
    z2hb_pkg::sts_t sts;

    z2hb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    z2hb_dp #(
        .TIME_LEN  (TIME_LEN),
        .SPACE_LEN (SPACE_LEN)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .func             (func),
        .time_coord       (time_coord),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .z_coord          (z_coord),
        .direction        (direction),
        .write_sign       (write_sign),
        .random_fraction  (random_fraction),
        .coupling_time    (coupling_time),
        .coupling_space   (coupling_space),
        .done             (done),
        .new_sign         (new_sign),
        .time_staple_sum  (time_staple_sum),
        .space_staple_sum (space_staple_sum)
    );

endmodule
